// ===== rtl/vsea_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vsea_pkg
// Shared types, widths and helpers for the vertical seam energy accumulator.
// ============================================================================
package vsea_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CFG_W     = 11;
    localparam int ENERGY_W  = 16;
    localparam int SUM_W     = 31;

    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam logic [CFG_W-1:0] WIDTH_RST = CFG_W'(1024);

    // Column position of one pixel as seen at the input
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             first;   // pixel belongs to the first row of a frame
        logic             last;    // rightmost column of its row
    } t_pos;

    // Clamp the programmed width to 2..MAX_WIDTH and return the last column index
    function automatic logic [COL_W-1:0] cfg_last_col(input logic [CFG_W-1:0] width);
        int w;
        w = int'(width);
        if (w < 2) begin
            w = 2;
        end
        if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        return COL_W'(w - 1);
    endfunction

    localparam logic [COL_W-1:0] LAST_COL_RST = cfg_last_col(WIDTH_RST);

endpackage

// ===== rtl/vertical_seam_energy_accumulate.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vertical_seam_energy_accumulate
// Cumulative vertical seam energy map over a raster pixel stream.
// ============================================================================
// Usage:
//   Input channel (i_valid/o_ready) takes one pixel energy per transaction in
//   raster order; i_frame_start marks the first pixel of an image. Output
//   channel (o_valid/i_ready) returns one summed energy per pixel, in order,
//   with o_saturated set when the sum clipped at 2^31-1.
//   Config channel (i_cfg_valid/o_cfg_ready) writes the image width; it is
//   always ready and should be written only while the block is empty.
//   Path: each pixel passes the read, left/above and output stage registers,
//   and o_valid comes from the output stage.
//   Throughput: one pixel per cycle while i_ready stays high, set by the loop
//   of right neighbor forwarding, compare and add in the last stage; the line
//   store has one write and two read ports.
//   Reset: width 1024, next pixel is column 0 of a first row, pipeline empty.
//   The line store is not cleared; the first row of a frame fills it.
//   Receiver stall: the three stages keep filling; o_ready drops only once
//   all of them hold pixels, and nothing is lost or repeated.
// ============================================================================
module vertical_seam_energy_accumulate (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vsea_pkg::CFG_W-1:0]    i_cfg_image_width,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [vsea_pkg::ENERGY_W-1:0] i_pixel_energy,
    input  logic                          i_frame_start,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [vsea_pkg::SUM_W-1:0]    o_summed_energy,
    output logic                          o_saturated
);
    import vsea_pkg::*;

    t_pos w_pos;
    logic w_in_ready;
    logic w_accept;

    assign w_accept    = i_valid && w_in_ready;
    assign o_ready     = w_in_ready;
    assign o_cfg_ready = 1'b1;

    vsea_col_track u_col_track (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_image_width (i_cfg_image_width),
        .i_frame_start     (i_frame_start),
        .i_accept          (w_accept),
        .o_pos             (w_pos)
    );

    vsea_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (w_in_ready),
        .i_pos           (w_pos),
        .i_pixel_energy  (i_pixel_energy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_summed_energy (o_summed_energy),
        .o_saturated     (o_saturated)
    );

endmodule

// ===== rtl/vsea_col_track.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vsea_col_track
// Width register and raster position tracker: tags each incoming pixel with
// its column and its first-row / last-column flags.
// ============================================================================
module vsea_col_track (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [vsea_pkg::CFG_W-1:0]   i_cfg_image_width,
    input  logic                         i_frame_start,
    input  logic                         i_accept,
    output vsea_pkg::t_pos               o_pos
);
    import vsea_pkg::*;

    logic [COL_W-1:0] r_last_col, n_last_col;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_first, n_first;
    t_pos             pos;

    always_comb begin
        pos.col   = i_frame_start ? '0 : r_col;
        pos.first = i_frame_start | r_first;
        // a shrunk width can leave the counter past the new last column
        pos.last  = (pos.col >= r_last_col);
    end

    always_comb begin
        n_last_col = i_cfg_valid ? cfg_last_col(i_cfg_image_width) : r_last_col;
        n_col      = r_col;
        n_first    = r_first;
        if (i_accept) begin
            if (pos.last) begin
                n_col   = '0;
                n_first = 1'b0;
            end else begin
                n_col   = pos.col + 1'b1;
                n_first = pos.first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= LAST_COL_RST;
            r_col      <= '0;
            r_first    <= 1'b1;
        end else begin
            r_last_col <= n_last_col;
            r_col      <= n_col;
            r_first    <= n_first;
        end
    end

    assign o_pos = pos;

endmodule

// ===== rtl/vsea_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vsea_datapath
// Three-stage pipeline with the previous-row line store: read, left/above
// minimum, right minimum plus add with saturation. Recent sums still in flight
// are forwarded from the output stage.
// ============================================================================
module vsea_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  vsea_pkg::t_pos                i_pos,
    input  logic [vsea_pkg::ENERGY_W-1:0] i_pixel_energy,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [vsea_pkg::SUM_W-1:0]    o_summed_energy,
    output logic                          o_saturated
);
    import vsea_pkg::*;

    logic [SUM_W-1:0] mem [MAX_WIDTH];

    logic w_en1, w_en2, w_en3, w_accept, w_wr_en;

    // stage 1: line store read
    logic                r_v1;
    logic [ENERGY_W-1:0] r_s1_energy;
    logic [COL_W-1:0]    r_s1_col;
    logic                r_s1_first, r_s1_last;
    logic [SUM_W-1:0]    r_rd_above, r_rd_right;

    // stage 2: left/above resolved
    logic                r_v2;
    logic [ENERGY_W-1:0] r_s2_energy;
    logic [COL_W-1:0]    r_s2_col;
    logic                r_s2_first, r_s2_last;
    logic [SUM_W-1:0]    r_s2_pl, r_s2_right;

    // stage 3: result
    logic                r_v3;
    logic [SUM_W-1:0]    r_s3_sum;
    logic                r_s3_sat, r_s3_first;
    logic [COL_W-1:0]    r_s3_col;

    logic [SUM_W-1:0]    r_left;

    logic [COL_W-1:0]    w_rd_right_addr, w_s1_right_col, w_s2_right_col;
    logic [SUM_W-1:0]    w_above, w_right1, w_pl, w_right2, w_best, w_sum;
    logic [SUM_W:0]      w_raw;
    logic                w_has_left, w_sat;

    assign w_en3    = !r_v3 || i_ready;
    assign w_en2    = !r_v2 || w_en3;
    assign w_en1    = !r_v1 || w_en2;
    assign w_accept = i_valid && w_en1;
    assign w_wr_en  = r_v2 && w_en3;

    assign w_rd_right_addr = i_pos.col + 1'b1;
    assign w_s1_right_col  = r_s1_col + 1'b1;
    assign w_s2_right_col  = r_s2_col + 1'b1;

    // stage 1 -> 2: sums written after this pixel's read sit in the output stage
    always_comb begin
        w_above    = (r_v3 && r_s3_col == r_s1_col) ? r_s3_sum : r_rd_above;
        w_right1   = (r_v3 && r_s3_col == w_s1_right_col) ? r_s3_sum : r_rd_right;
        w_has_left = (r_s1_col != '0);
        w_pl       = (w_has_left && r_left < w_above) ? r_left : w_above;
    end

    // stage 2 -> 3: the pixel just ahead may have written the right neighbor
    always_comb begin
        w_right2 = (r_v3 && r_s3_col == w_s2_right_col) ? r_s3_sum : r_s2_right;
        w_best   = (!r_s2_last && w_right2 < r_s2_pl) ? w_right2 : r_s2_pl;
        if (r_s2_first) begin
            w_raw = (SUM_W+1)'(r_s2_energy);
        end else begin
            w_raw = {1'b0, w_best} + (SUM_W+1)'(r_s2_energy);
        end
        w_sat = w_raw[SUM_W];
        w_sum = w_sat ? SUM_MAX : w_raw[SUM_W-1:0];
    end

    // line store: read-old on a same-address write
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_s2_col] <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_above <= mem[i_pos.col];
            r_rd_right <= mem[w_rd_right_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_energy <= i_pixel_energy;
            r_s1_col    <= i_pos.col;
            r_s1_first  <= i_pos.first;
            r_s1_last   <= i_pos.last;
        end
        if (r_v1 && w_en2) begin
            r_s2_energy <= r_s1_energy;
            r_s2_col    <= r_s1_col;
            r_s2_first  <= r_s1_first;
            r_s2_last   <= r_s1_last;
            r_s2_pl     <= w_pl;
            r_s2_right  <= w_right1;
            // old sum above this column is the next pixel's left neighbor
            r_left      <= w_above;
        end
        if (w_wr_en) begin
            r_s3_sum   <= w_sum;
            r_s3_sat   <= w_sat;
            r_s3_first <= r_s2_first;
            r_s3_col   <= r_s2_col;
        end
    end

    assign o_ready         = w_en1;
    assign o_valid         = r_v3;
    assign o_summed_energy = r_s3_sum;
    assign o_saturated     = r_s3_sat;

    a_sat_clips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_s3_sat |-> r_s3_sum == SUM_MAX)
        else $error("saturated result not clipped to maximum");

    a_first_row_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_s3_first |-> !r_s3_sat)
        else $error("first-row pixel flagged as saturated");

    a_write_lands_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> r_v3 && r_s3_col == $past(r_s2_col))
        else $error("line store write not matched by output stage");

endmodule
